// ===== hw/rtl/group_number_compactor_defines.svh =====
// ----------------------------------------------------------------------------
// group_number_compactor_defines.svh
// Assertion macros used by the checker of the group number compactor.
// ----------------------------------------------------------------------------
`ifndef GROUP_NUMBER_COMPACTOR_DEFINES_SVH
`define GROUP_NUMBER_COMPACTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GNC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group_number_compactor check failed");

// next-cycle implication, sampled on clk, off during reset
`define GNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group_number_compactor check failed");

`endif

// ===== hw/rtl/gnc_pkg.sv =====
// ----------------------------------------------------------------------------
// gnc_pkg
// Field widths, limits and word types of the group number compactor.
// ----------------------------------------------------------------------------
`default_nettype none

package gnc_pkg;

    localparam int KIND_W  = 8;
    localparam int GID_W   = 16;
    localparam int CID_W   = 9;
    localparam int SEEN_W  = 5;

    // per-type counter saturates here; a further new number overflows
    localparam logic [CID_W-1:0] COUNT_MAX = 9'd511;

    // word handed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0] group_kind;
        logic [GID_W-1:0]  group_id;
        logic              ignored;
    } item_t;

    // result word
    typedef struct packed {
        logic [CID_W-1:0]  compact_id;
        logic              kind_is_new;
        logic              id_is_new;
        logic [SEEN_W-1:0] kinds_seen;
        logic              ignored;
        logic              overflow;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gnc_if.sv =====
// ----------------------------------------------------------------------------
// gnc_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnc_in_if import gnc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] group_kind;
    logic [GID_W-1:0]  group_id;

    modport source (output valid, output group_kind, output group_id, input ready);
    modport sink   (input valid, input group_kind, input group_id, output ready);
endinterface

interface gnc_out_if import gnc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CID_W-1:0]  compact_id;
    logic              kind_is_new;
    logic              id_is_new;
    logic [SEEN_W-1:0] kinds_seen;
    logic              ignored;
    logic              overflow;

    modport source (output valid, output compact_id, output kind_is_new,
                    output id_is_new, output kinds_seen, output ignored,
                    output overflow, input ready);
    modport sink   (input valid, input compact_id, input kind_is_new,
                    input id_is_new, input kinds_seen, input ignored,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gnc_ram.sv =====
// ----------------------------------------------------------------------------
// gnc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gnc_front.sv =====
// ----------------------------------------------------------------------------
// gnc_front
// Takes input words, trims the number to its used bits and marks zero pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module gnc_front import gnc_pkg::*; #(
    parameter int ID_BITS = 16
) (
    gnc_in_if.sink      in_ch,
    input  wire logic   q_full,
    output logic        push,
    output item_t       push_item
);

    logic [ID_BITS-1:0] id_used;

    // only the low ID_BITS bits of the number count
    assign id_used = ID_BITS'(in_ch.group_id);

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        push_item.group_kind = in_ch.group_kind;
        push_item.group_id   = GID_W'(id_used);
        push_item.ignored    = (in_ch.group_kind == '0) || (id_used == '0);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gnc_queue.sv =====
// ----------------------------------------------------------------------------
// gnc_queue
// Two-entry queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gnc_queue import gnc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       avail,
    output item_t      head
);

    item_t       slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gnc_back.sv =====
// ----------------------------------------------------------------------------
// gnc_back
// Type lookup, serial walk of the entry RAM, insertion and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gnc_back import gnc_pkg::*; #(
    parameter int MAX_KINDS   = 16,
    parameter int MAX_ENTRIES = 256,
    parameter int ID_BITS     = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_avail,
    input  item_t      q_head,
    output logic       pop,
    gnc_out_if.source  out_ch
);

    localparam int SLOT_W = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
    localparam int KT_W   = $clog2(MAX_KINDS + 1);
    localparam int EA_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W = SLOT_W + ID_BITS + CID_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD,
        S_CMP,
        S_INS,
        S_OUT
    } state_t;

    state_t              state_reg;
    item_t               item_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                new_kind_reg;
    logic [EA_W-1:0]     scan_idx_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [KT_W-1:0]     kinds_total_reg;
    logic [MAX_KINDS-1:0] kind_valid_reg;
    logic [KIND_W-1:0]   kind_key_reg   [MAX_KINDS];
    logic [CID_W-1:0]    kind_count_reg [MAX_KINDS];
    result_t             res_reg;
    logic                out_valid_reg;

    logic                hit;
    logic [SLOT_W-1:0]   hit_slot;
    logic [ID_BITS-1:0]  item_id;
    logic [CID_W-1:0]    cnt_cur;
    logic [CID_W-1:0]    cnt_new;
    logic                ins_ok;
    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [SLOT_W-1:0]   rd_slot;
    logic [ID_BITS-1:0]  rd_id;
    logic [CID_W-1:0]    rd_compact;
    logic                rd_match;
    logic                scan_last;
    logic [KT_W-1:0]     total_inc;

    assign item_id = ID_BITS'(item_reg.group_id);

    // row of compares over the type slots; a type sits in one slot at most
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < MAX_KINDS; i++)
        begin
            if (kind_valid_reg[i] && (kind_key_reg[i] == item_reg.group_kind))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    // entry word read back during the walk
    assign rd_slot    = ram_rdata[WORD_W-1 -: SLOT_W];
    assign rd_id      = ram_rdata[CID_W +: ID_BITS];
    assign rd_compact = ram_rdata[CID_W-1:0];
    assign rd_match   = (rd_slot == slot_reg) && (rd_id == item_id);
    assign scan_last  = ((FILL_W'(scan_idx_reg) + 1'b1) == fill_reg);

    // insertion check
    assign cnt_cur   = kind_count_reg[slot_reg];
    assign cnt_new   = new_kind_reg ? CID_W'(1) : (cnt_cur + 1'b1);
    assign ins_ok    = (fill_reg != FILL_W'(MAX_ENTRIES)) &&
                       (new_kind_reg || (cnt_cur < COUNT_MAX));
    assign ram_we    = (state_reg == S_INS) && ins_ok;
    assign ram_wdata = {slot_reg, item_id, cnt_new};
    assign total_inc = kinds_total_reg + 1'b1;

    gnc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[EA_W-1:0]),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign pop = (state_reg == S_IDLE) && q_avail;

    // sequencer, tables and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            kinds_total_reg <= '0;
            kind_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
            scan_idx_reg    <= '0;
            res_reg         <= '0;
            for (int i = 0; i < MAX_KINDS; i++)
            begin
                kind_count_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_avail)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    // zero pair or full type table settles the word here
                    res_reg <= '{compact_id:  '0,
                                 kind_is_new: 1'b0,
                                 id_is_new:   1'b0,
                                 kinds_seen:  SEEN_W'(kinds_total_reg),
                                 ignored:     item_reg.ignored,
                                 overflow:    !item_reg.ignored && !hit &&
                                              (kinds_total_reg == KT_W'(MAX_KINDS))};
                    scan_idx_reg <= '0;
                    if (item_reg.ignored)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (hit)
                    begin
                        state_reg <= (fill_reg == '0) ? S_INS : S_RD;
                    end
                    else if (kinds_total_reg == KT_W'(MAX_KINDS))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_INS;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_match)
                    begin
                        res_reg.compact_id <= rd_compact;
                        state_reg          <= S_OUT;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        state_reg    <= S_RD;
                    end
                end
                S_INS:
                begin
                    if (ins_ok)
                    begin
                        fill_reg                 <= fill_reg + 1'b1;
                        kind_count_reg[slot_reg] <= cnt_new;
                        res_reg <= '{compact_id:  cnt_new,
                                     kind_is_new: new_kind_reg,
                                     id_is_new:   1'b1,
                                     kinds_seen:  new_kind_reg ? SEEN_W'(total_inc)
                                                               : res_reg.kinds_seen,
                                     ignored:     1'b0,
                                     overflow:    1'b0};
                        if (new_kind_reg)
                        begin
                            kind_valid_reg[slot_reg] <= 1'b1;
                            kinds_total_reg          <= total_inc;
                        end
                    end
                    else
                    begin
                        res_reg.overflow <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_valid_reg && out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload: current word, its type slot and the type keys
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_head;
        end
        if (state_reg == S_LOOK)
        begin
            slot_reg     <= hit ? hit_slot : kinds_total_reg[SLOT_W-1:0];
            new_kind_reg <= !hit;
        end
        if (ram_we && new_kind_reg)
        begin
            kind_key_reg[slot_reg] <= item_reg.group_kind;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.compact_id  = res_reg.compact_id;
    assign out_ch.kind_is_new = res_reg.kind_is_new;
    assign out_ch.id_is_new   = res_reg.id_is_new;
    assign out_ch.kinds_seen  = res_reg.kinds_seen;
    assign out_ch.ignored     = res_reg.ignored;
    assign out_ch.overflow    = res_reg.overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/group_number_compactor.sv =====
// ----------------------------------------------------------------------------
// group_number_compactor
// Renumbers (group type, group number) pairs into dense per-type numbers.
// ----------------------------------------------------------------------------
//  channel   dir   word                                 handshake
//  in_ch     in    group_kind, group_id                 valid / ready
//  out_ch    out   compact_id, kind_is_new, id_is_new,  valid / ready
//                  kinds_seen, ignored, overflow
//
//  Each word walks the entries stored so far in the single-read-port entry
//  RAM, in a read state and a compare state per entry. Zero pairs and
//  type-table overflows skip the walk. A two-word queue keeps in_ch open
//  while the back is busy or out_ch stalls. Reset clears type slots and the
//  entry fill count at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module group_number_compactor import gnc_pkg::*; #(
    parameter int MAX_KINDS   = 16,
    parameter int MAX_ENTRIES = 256,
    parameter int ID_BITS     = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gnc_in_if.sink     in_ch,
    gnc_out_if.source  out_ch
);

    logic   push;
    item_t  push_item;
    logic   q_full;
    logic   q_avail;
    logic   pop;
    item_t  q_head;

    gnc_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    gnc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    gnc_back #(
        .MAX_KINDS   (MAX_KINDS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_head  (q_head),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gnc_checker.sv =====
// ----------------------------------------------------------------------------
// gnc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "group_number_compactor_defines.svh"
`default_nettype none

module gnc_checker import gnc_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CID_W-1:0]  compact_id,
    input wire logic              kind_is_new,
    input wire logic              id_is_new,
    input wire logic              ignored,
    input wire logic              overflow
);

    // a stalled result stays offered
    `GNC_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)

    // an ignored pair carries no number and no flags
    `GNC_ASSERT_NOW(a_ignored_clean, out_valid && ignored,
        compact_id == '0 && !kind_is_new && !id_is_new && !overflow)

    // an overflow stores nothing and returns zero
    `GNC_ASSERT_NOW(a_overflow_clean, out_valid && overflow,
        compact_id == '0 && !kind_is_new && !id_is_new && !ignored)

    // a fresh type always opens with its first number
    `GNC_ASSERT_NOW(a_new_kind_first, out_valid && kind_is_new,
        id_is_new && compact_id == CID_W'(1))

endmodule

bind group_number_compactor gnc_checker u_gnc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .compact_id  (out_ch.compact_id),
    .kind_is_new (out_ch.kind_is_new),
    .id_is_new   (out_ch.id_is_new),
    .ignored     (out_ch.ignored),
    .overflow    (out_ch.overflow)
);

`default_nettype wire
